### rtl/core/ttc_pkg.sv
`default_nettype none

package ttc_pkg;

  localparam int WORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  // what the back end does with an item
  typedef enum logic [1:0] {
    MODE_DIRECT,   // single quotient: gap/velocity, or -v/a at a double root
    MODE_QUAD,     // two roots, (sqrt(disc) - v)/a tried first
    MODE_STILL,    // no acceleration and no velocity
    MODE_NOROOT    // negative discriminant
  } mode_t;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_STILL  = 2'd1;
  localparam logic [1:0] ST_NOROOT = 2'd2;
  localparam logic [1:0] ST_OVF    = 2'd3;

endpackage

`default_nettype wire

### rtl/core/ttc_front.sv
`default_nettype none

module ttc_front #(
  parameter int W = ttc_pkg::WORD_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [W-1:0] accel,
  input  logic signed [W-1:0] init_velocity,
  input  logic signed [W-1:0] gap_distance,
  input  logic                q_full,
  output logic                q_push,
  output ttc_pkg::mode_t      q_mode,
  output logic signed [W-1:0] q_a,
  output logic signed [W-1:0] q_v,
  output logic signed [W-1:0] q_d,
  output logic [2*W-1:0]      q_disc
);
  import ttc_pkg::*;

  logic              en;
  logic [W-1:0]      a_mag, v_mag, d_mag;

  logic              s1_valid;
  logic signed [W-1:0] s1_a, s1_v, s1_d;
  logic [2*W-1:0]    s1_vv, s1_ad;
  logic              s1_adneg;

  logic              s2_valid;
  logic [2*W+1:0]    vv_x, ad2, qs;
  mode_t             mode_next;

  assign en       = !(s2_valid && q_full);
  assign in_ready = en;
  assign q_push   = s2_valid && !q_full;

  assign a_mag = accel[W-1]         ? W'(-accel)         : W'(accel);
  assign v_mag = init_velocity[W-1] ? W'(-init_velocity) : W'(init_velocity);
  assign d_mag = gap_distance[W-1]  ? W'(-gap_distance)  : W'(gap_distance);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
    end
    if (en) begin
      s1_a     <= accel;
      s1_v     <= init_velocity;
      s1_d     <= gap_distance;
      s1_vv    <= (2*W)'(v_mag) * (2*W)'(v_mag);
      s1_ad    <= (2*W)'(a_mag) * (2*W)'(d_mag);
      s1_adneg <= (accel[W-1] ^ gap_distance[W-1]) && (gap_distance != '0);
    end
  end

  // discriminant v*v + 2*a*d, signed so its sign shows a missing real root
  assign vv_x = (2*W+2)'(s1_vv);
  assign ad2  = (2*W+2)'({s1_ad, 1'b0});
  assign qs   = s1_adneg ? (vv_x - ad2) : (vv_x + ad2);

  always_comb begin
    if (s1_a == '0) begin
      mode_next = (s1_v == '0) ? MODE_STILL : MODE_DIRECT;
    end else if (qs[2*W+1]) begin
      mode_next = MODE_NOROOT;
    end else if (qs == '0) begin
      mode_next = MODE_DIRECT;
    end else begin
      mode_next = MODE_QUAD;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
    end
    if (en) begin
      q_mode <= mode_next;
      q_a    <= s1_a;
      q_v    <= s1_v;
      q_d    <= s1_d;
      q_disc <= qs[2*W-1:0];
    end
  end

endmodule

`default_nettype wire

### rtl/core/ttc_fifo.sv
`default_nettype none

module ttc_fifo #(
  parameter int EW    = 8,
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  logic [EW-1:0] din,
  output logic          full,
  input  logic          pop,
  output logic [EW-1:0] dout,
  output logic          empty
);
  localparam int AW = $clog2(DEPTH);

  logic [EW-1:0] mem [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [AW:0]   count;

  assign full  = (count == (AW+1)'(DEPTH));
  assign empty = (count == '0);
  assign dout  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

endmodule

`default_nettype wire

### rtl/core/ttc_sqrt.sv
`default_nettype none

// digit-by-digit integer square root, one result bit per stage
module ttc_sqrt #(
  parameter int W  = 32,
  parameter int SW = 8
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  logic [2*W-1:0] in_q,
  input  logic [SW-1:0]  in_side,
  output logic           out_valid,
  output logic [W-1:0]   out_root,
  output logic [SW-1:0]  out_side
);
  localparam int RW = W + 2;

  logic           vld_r  [W];
  logic [RW-1:0]  rem_r  [W];
  logic [W-1:0]   root_r [W];
  logic [2*W-1:0] x_r    [W];
  logic [SW-1:0]  side_r [W];

  for (genvar i = 0; i < W; i++) begin : g_stage
    logic           p_vld;
    logic [RW-1:0]  p_rem;
    logic [W-1:0]   p_root;
    logic [2*W-1:0] p_x;
    logic [SW-1:0]  p_side;
    logic [RW+1:0]  rs, trial;
    logic           ge;

    if (i == 0) begin : g_in
      assign p_vld  = in_valid;
      assign p_rem  = '0;
      assign p_root = '0;
      assign p_x    = in_q;
      assign p_side = in_side;
    end else begin : g_link
      assign p_vld  = vld_r[i-1];
      assign p_rem  = rem_r[i-1];
      assign p_root = root_r[i-1];
      assign p_x    = x_r[i-1];
      assign p_side = side_r[i-1];
    end

    assign rs    = {p_rem, p_x[2*W-1:2*W-2]};
    assign trial = (RW+2)'({p_root, 2'b01});
    assign ge    = (rs >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= p_vld;
      end
      if (en) begin
        rem_r[i]  <= ge ? RW'(rs - trial) : RW'(rs);
        root_r[i] <= {p_root[W-2:0], ge};
        x_r[i]    <= {p_x[2*W-3:0], 2'b00};
        side_r[i] <= p_side;
      end
    end
  end

  assign out_valid = vld_r[W-1];
  assign out_root  = root_r[W-1];
  assign out_side  = side_r[W-1];

endmodule

`default_nettype wire

### rtl/core/ttc_div.sv
`default_nettype none

// restoring unsigned divider, one quotient bit per stage
module ttc_div #(
  parameter int NB = 49,
  parameter int DW = 32,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NB-1:0] in_num,
  input  logic [DW-1:0] in_den,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [NB-1:0] out_quo,
  output logic [SW-1:0] out_side
);
  logic          vld_r  [NB];
  logic [DW-1:0] rem_r  [NB];
  logic [NB-1:0] x_r    [NB];
  logic [DW-1:0] den_r  [NB];
  logic [SW-1:0] side_r [NB];

  for (genvar i = 0; i < NB; i++) begin : g_stage
    logic          p_vld;
    logic [DW-1:0] p_rem;
    logic [NB-1:0] p_x;
    logic [DW-1:0] p_den;
    logic [SW-1:0] p_side;
    logic [DW:0]   rs, dx;
    logic          ge;

    if (i == 0) begin : g_in
      assign p_vld  = in_valid;
      assign p_rem  = '0;
      assign p_x    = in_num;
      assign p_den  = in_den;
      assign p_side = in_side;
    end else begin : g_link
      assign p_vld  = vld_r[i-1];
      assign p_rem  = rem_r[i-1];
      assign p_x    = x_r[i-1];
      assign p_den  = den_r[i-1];
      assign p_side = side_r[i-1];
    end

    // numerator bits shift out the top, quotient bits shift in below
    assign rs = {p_rem, p_x[NB-1]};
    assign dx = {1'b0, p_den};
    assign ge = (rs >= dx);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= p_vld;
      end
      if (en) begin
        rem_r[i]  <= ge ? DW'(rs - dx) : DW'(rs);
        x_r[i]    <= {p_x[NB-2:0], ge};
        den_r[i]  <= p_den;
        side_r[i] <= p_side;
      end
    end
  end

  assign out_valid = vld_r[NB-1];
  assign out_quo   = x_r[NB-1];
  assign out_side  = side_r[NB-1];

endmodule

`default_nettype wire

### rtl/core/ttc_back.sv
`default_nettype none

module ttc_back #(
  parameter int W = ttc_pkg::WORD_WIDTH_DEF,
  parameter int F = ttc_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_pop,
  input  ttc_pkg::mode_t      in_mode,
  input  logic signed [W-1:0] in_a,
  input  logic signed [W-1:0] in_v,
  input  logic signed [W-1:0] in_d,
  input  logic [2*W-1:0]      in_disc,
  input  logic                out_ready,
  output logic                out_valid,
  output logic [W-1:0]        out_time,
  output logic [1:0]          out_status
);
  import ttc_pkg::*;

  localparam int NB = W + 1 + F;
  localparam int SW = 2 + 3 * W;

  logic                en;

  logic                sq_valid;
  logic [W-1:0]        sq_root;
  logic [SW-1:0]       sq_side;
  mode_t               s_mode;
  logic signed [W-1:0] s_a, s_v, s_d, den;
  logic signed [W+1:0] sv, sd, sr, n1, n2;
  logic                az;

  logic                m_valid;
  mode_t               m_mode;
  logic [NB-1:0]       m_num1, m_num2;
  logic [W-1:0]        m_den;
  logic                m_neg1, m_neg2;

  logic                d1_valid, d2_valid;
  logic [NB-1:0]       d1_quo, d2_quo;
  logic [2:0]          d1_side;
  logic                d2_side;
  mode_t               f_mode;
  logic [W+1:0]        r1, r2, rsel;

  assign en     = !out_valid || out_ready;
  assign in_pop = en && in_valid;

  ttc_sqrt #(.W(W), .SW(SW)) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (in_valid),
    .in_q     (in_disc),
    .in_side  ({in_mode, in_a, in_v, in_d}),
    .out_valid(sq_valid),
    .out_root (sq_root),
    .out_side (sq_side)
  );

  assign s_mode = mode_t'(sq_side[SW-1 -: 2]);
  assign s_a    = $signed(sq_side[3*W-1:2*W]);
  assign s_v    = $signed(sq_side[2*W-1:W]);
  assign s_d    = $signed(sq_side[W-1:0]);

  // numerators: gap when a is zero, else s - v and -v - s
  assign az  = (s_a == '0);
  assign sv  = (W+2)'(s_v);
  assign sd  = (W+2)'(s_d);
  assign sr  = $signed({2'b00, sq_root});
  assign n1  = az ? sd : (sr - sv);
  assign n2  = -sv - sr;
  assign den = az ? s_v : s_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (en) begin
      m_valid <= sq_valid;
    end
    if (en) begin
      m_mode <= s_mode;
      m_num1 <= {(n1[W+1] ? (W+1)'(-n1) : (W+1)'(n1)), {F{1'b0}}};
      m_num2 <= {(n2[W+1] ? (W+1)'(-n2) : (W+1)'(n2)), {F{1'b0}}};
      m_den  <= den[W-1] ? W'(-den) : W'(den);
      m_neg1 <= n1[W+1] ^ den[W-1];
      m_neg2 <= n2[W+1] ^ den[W-1];
    end
  end

  ttc_div #(.NB(NB), .DW(W), .SW(3)) u_div1 (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (m_valid),
    .in_num   (m_num1),
    .in_den   (m_den),
    .in_side  ({m_mode, m_neg1}),
    .out_valid(d1_valid),
    .out_quo  (d1_quo),
    .out_side (d1_side)
  );

  ttc_div #(.NB(NB), .DW(W), .SW(1)) u_div2 (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (m_valid),
    .in_num   (m_num2),
    .in_den   (m_den),
    .in_side  (m_neg2),
    .out_valid(d2_valid),
    .out_quo  (d2_quo),
    .out_side (d2_side)
  );

  // signed, saturated time with its status in the top two bits
  function automatic logic [W+1:0] fix_q(input logic [NB-1:0] q, input logic neg);
    logic [NB-1:0] lim;
    logic [W-1:0]  t;
    logic          ovf;
    lim = (NB'(1) << (W - 1)) - NB'(!neg);
    ovf = (q > lim);
    t   = neg ? W'(NB'(0) - q) : W'(q);
    if (ovf) begin
      t = W'(lim);
    end
    return {(ovf ? ST_OVF : ST_OK), t};
  endfunction

  assign f_mode = mode_t'(d1_side[2:1]);
  assign r1     = fix_q(d1_quo, d1_side[0]);
  assign r2     = fix_q(d2_quo, d2_side);

  always_comb begin
    case (f_mode)
      MODE_STILL:  rsel = {ST_STILL, W'(0)};
      MODE_NOROOT: rsel = {ST_NOROOT, W'(0)};
      // first root not positive: take the other one
      MODE_QUAD:   rsel = ((r1[W-1:0] == '0) || r1[W-1]) ? r2 : r1;
      default:     rsel = r1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= d1_valid && d2_valid;
    end
    if (en) begin
      out_time   <= rsel[W-1:0];
      out_status <= rsel[W+1:W];
    end
  end

endmodule

`default_nettype wire

### rtl/core/time_to_collision_solver_unit.sv
`default_nettype none

// Time-to-collision solver: for signed fixed-point acceleration a, velocity v and gap d
// it solves d = v*t + a*t*t/2 and returns t (same fixed-point format) with a 2-bit status
// in tuser (ok, not moving, no real root, saturated). One word is accepted per clock and
// results leave in input order at one per clock while neither the queue nor the receiver
// stalls. The back end is the square-root pipeline (one root bit per stage) followed by
// the two parallel divider pipelines (one quotient bit per stage). A four-entry queue
// separates the discriminant front end from the root/divide back end so either side
// can stall independently.
module time_to_collision_solver_unit #(
  parameter int WORD_WIDTH = ttc_pkg::WORD_WIDTH_DEF,
  parameter int FRAC_BITS  = ttc_pkg::FRAC_BITS_DEF,
  localparam int IN_TW     = ((3 * WORD_WIDTH + 7) / 8) * 8,
  localparam int OUT_TW    = ((WORD_WIDTH + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [IN_TW-1:0]  s_axis_tdata,  // accel, init_velocity, gap_distance
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [OUT_TW-1:0] m_axis_tdata,  // time_est
  output logic [1:0]        m_axis_tuser   // status
);
  import ttc_pkg::*;

  localparam int W     = WORD_WIDTH;
  localparam int EW    = 2 + 5 * W;
  localparam int DEPTH = 4;

  logic                q_full, q_empty, q_push, q_pop;
  mode_t               f_mode;
  logic signed [W-1:0] f_a, f_v, f_d;
  logic [2*W-1:0]      f_disc;
  logic [EW-1:0]       q_din, q_dout;
  logic [W-1:0]        time_w;

  ttc_front #(.W(W)) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_axis_tvalid),
    .in_ready     (s_axis_tready),
    .accel        ($signed(s_axis_tdata[W-1:0])),
    .init_velocity($signed(s_axis_tdata[2*W-1:W])),
    .gap_distance ($signed(s_axis_tdata[3*W-1:2*W])),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_mode       (f_mode),
    .q_a          (f_a),
    .q_v          (f_v),
    .q_d          (f_d),
    .q_disc       (f_disc)
  );

  assign q_din = {f_mode, f_a, f_v, f_d, f_disc};

  ttc_fifo #(.EW(EW), .DEPTH(DEPTH)) u_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (q_push),
    .din  (q_din),
    .full (q_full),
    .pop  (q_pop),
    .dout (q_dout),
    .empty(q_empty)
  );

  ttc_back #(.W(W), .F(FRAC_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (!q_empty),
    .in_pop    (q_pop),
    .in_mode   (mode_t'(q_dout[EW-1 -: 2])),
    .in_a      ($signed(q_dout[5*W-1:4*W])),
    .in_v      ($signed(q_dout[4*W-1:3*W])),
    .in_d      ($signed(q_dout[3*W-1:2*W])),
    .in_disc   (q_dout[2*W-1:0]),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_time  (time_w),
    .out_status(m_axis_tuser)
  );

  assign m_axis_tdata = OUT_TW'(time_w);

endmodule

`default_nettype wire

### rtl/core/ttc_checker.sv
`default_nettype none

module ttc_checker #(
  parameter int WORD_WIDTH = ttc_pkg::WORD_WIDTH_DEF,
  parameter int OUT_TW     = ((WORD_WIDTH + 7) / 8) * 8
) (
  input logic              clk,
  input logic              rst,
  input logic              m_axis_tvalid,
  input logic              m_axis_tready,
  input logic [OUT_TW-1:0] m_axis_tdata,
  input logic [1:0]        m_axis_tuser
);
  import ttc_pkg::*;

  localparam int W = WORD_WIDTH;

  logic [W-1:0] t;
  assign t = m_axis_tdata[W-1:0];

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result word dropped while stalled");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result word shown right after reset");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == ST_STILL || m_axis_tuser == ST_NOROOT) |-> t == '0)
    else $error("error status with nonzero time");

  a_sat_limit: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == ST_OVF |->
      t == {1'b1, {(W-1){1'b0}}} || t == {1'b0, {(W-1){1'b1}}})
    else $error("overflow status without a saturated time");

endmodule

bind time_to_collision_solver_unit ttc_checker #(.WORD_WIDTH(WORD_WIDTH)) u_ttc_checker (
  .clk          (clk),
  .rst          (rst),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser)
);

`default_nettype wire

### verif/ttc_checker.sv
`timescale 1ns / 100ps

module ttc_scoreboard (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,
  input  logic [1:0]  m_axis_tuser,
  output int          fail_count,
  output int          pending
);
  import ttc_pkg::*;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] t;
  } ttc_result_t;

  ttc_result_t expected_q[$];

  assign pending = expected_q.size();

  // magnitude of a signed 64-bit value
  function automatic logic [63:0] abs64(logic signed [63:0] x);
    return x < 0 ? -x : x;
  endfunction

  // (num << 16) / den, truncated toward zero, saturated to 32 bits
  function automatic ttc_result_t fixed_quotient(logic signed [63:0] num,
                                                 logic signed [63:0] den);
    ttc_result_t r;
    logic neg;
    logic [127:0] m;
    logic [127:0] lim;
    neg = (num < 0) != (den < 0);
    m = ({64'd0, abs64(num)} << 16) / {64'd0, abs64(den)};
    lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
    if (m > lim) begin
      r.t = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
      r.status = ST_OVF;
    end else begin
      r.t = neg ? -m[31:0] : m[31:0];
      r.status = ST_OK;
    end
    return r;
  endfunction

  function automatic logic [63:0] isqrt(logic [127:0] q);
    logic [63:0] res;
    logic [63:0] cand;
    res = 0;
    for (int b = 63; b >= 0; b--) begin
      cand = res | (64'd1 << b);
      if ({64'd0, cand} * {64'd0, cand} <= q) res = cand;
    end
    return res;
  endfunction

  function automatic ttc_result_t solve_collision_time(logic [95:0] word);
    logic signed [63:0] a, v, d, s;
    logic signed [129:0] disc;
    ttc_result_t r;
    a = $signed(word[31:0]);
    v = $signed(word[63:32]);
    d = $signed(word[95:64]);
    r = '0;
    if (a == 0) begin
      if (v != 0) r = fixed_quotient(d, v);
      else r.status = ST_STILL;
    end else begin
      disc = 130'(v) * 130'(v) + 130'sd2 * 130'(a) * 130'(d);
      if (disc < 0) r.status = ST_NOROOT;
      else if (disc == 0) r = fixed_quotient(-v, a);
      else begin
        s = isqrt(disc[127:0]);
        r = fixed_quotient(s - v, a);
        // the quantized first root has to be strictly positive
        if (r.t == 0 || r.t[31]) r = fixed_quotient(-v - s, a);
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    ttc_result_t exp_r;
    if (rst) begin
      fail_count <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        expected_q.push_back(solve_collision_time(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result word: time_est %h status %0d", m_axis_tdata, m_axis_tuser);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = expected_q.pop_front();
          if (m_axis_tdata !== exp_r.t || m_axis_tuser !== exp_r.status) begin
            if (m_axis_tdata !== exp_r.t)
              $error("time_est: expected %h actual %h", exp_r.t, m_axis_tdata);
            if (m_axis_tuser !== exp_r.status)
              $error("status: expected %0d actual %0d", exp_r.status, m_axis_tuser);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

### verif/tb.sv
`timescale 1ns / 100ps

module tb;
  logic        clk = 0;
  logic        rst = 1;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [95:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [31:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  int          fail_count;
  int          pending;
  logic        hold_off = 0;
  logic        send_done = 0;

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  time_to_collision_solver_unit i_dut (.*);

  ttc_scoreboard i_checker (.*);

  function automatic logic [31:0] random_field();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'd0;
      3: return $urandom_range(0, 1) ? 32'h0001_0000 : 32'hFFFF_0000;
      4: return $signed($urandom_range(0, 2047)) - 1024;
      5: return $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
      default: return $urandom();
    endcase
  endfunction

  // valid drops only for a real gap, so back-to-back words keep it high
  task automatic send_word(logic [31:0] a, logic [31:0] v, logic [31:0] d);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      s_axis_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= {d, v, a};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // receiver: random stalls plus one long hold-off
  initial begin
    int w;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_off) begin
        m_axis_tready <= 0;
      end else begin
        w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
        if (w == 0) begin
          m_axis_tready <= 1;
        end else begin
          m_axis_tready <= 0;
          repeat (w - 1) @(posedge clk);
        end
      end
    end
  end

  initial begin
    logic [31:0] a, v, d;
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed corners
    send_word(0, 0, 0);
    send_word(0, 0, 32'h7FFF_FFFF);
    send_word(0, 32'h0002_0000, 32'h000A_0000);
    send_word(0, 32'h0000_0001, 32'h7FFF_FFFF);
    send_word(0, 32'h8000_0000, 32'h8000_0000);
    send_word(0, 32'hFFFF_0000, 32'h0001_0000);
    send_word(32'h0001_0000, 32'h0001_0000, 32'hFFFF_0000);
    send_word(32'hFFFF_0000, 32'h0002_0000, 32'h0002_0000);
    send_word(32'h0002_0000, 32'hFFFE_0000, 32'hFFFF_0000);
    send_word(32'h0001_0000, 0, 32'hFFFF_0000);
    send_word(32'h0002_0000, 32'h0003_0000, 32'h0004_0000);
    send_word(32'h0002_0000, 32'hFFFD_0000, 32'h0004_0000);
    send_word(32'h0000_0001, 32'h0000_0001, 32'h0000_0001);
    send_word(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_word(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_word(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_word(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001);
    send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // long receiver stall while the sender keeps offering words
    hold_off <= 1;
    fork
      begin
        repeat (400) @(posedge clk);
        hold_off <= 0;
      end
      for (int i = 0; i < 150; i++) begin
        a = random_field();
        v = random_field();
        d = random_field();
        s_axis_tvalid <= 1;
        s_axis_tdata <= {d, v, a};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
      end
    join
    for (int i = 0; i < 830; i++) begin
      a = random_field();
      v = random_field();
      d = random_field();
      send_word(a, v, d);
    end
    s_axis_tvalid <= 0;
    send_done <= 1;
  end

  initial begin
    wait (send_done);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("tb: failure");
    $finish;
  end
endmodule

### sim.f
rtl/core/ttc_pkg.sv
rtl/core/ttc_front.sv
rtl/core/ttc_fifo.sv
rtl/core/ttc_sqrt.sv
rtl/core/ttc_div.sv
rtl/core/ttc_back.sv
rtl/core/time_to_collision_solver_unit.sv
rtl/core/ttc_checker.sv
verif/ttc_checker.sv
verif/tb.sv
